### src/circular_list_engine_core_defines.svh
// Assertion macros for the circular list engine checker.
// Needs nothing else; taken in by the checker file only.
`ifndef CIRCULAR_LIST_ENGINE_CORE_DEFINES_SVH
`define CIRCULAR_LIST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, switched off while rst is high.
`define CLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while rst is high.
`define CLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/cle_pkg.sv
// Shared constants and codes of the circular list engine.
// No dependencies; used by every module of the block.
`default_nettype none

package cle_pkg;

   localparam int unsigned DATA_W       = 32;
   localparam int unsigned OP_W         = 2;
   localparam int unsigned ST_W         = 2;
   localparam int unsigned CNT_W        = 5;
   localparam int unsigned CAPACITY_DEF = 16;

   typedef enum logic [OP_W-1:0] {
      OP_FRONT  = 2'd0,
      OP_BACK   = 2'd1,
      OP_DELETE = 2'd2,
      OP_READ   = 2'd3
   } opcode_type;

   typedef enum logic [ST_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

endpackage

`default_nettype wire

### src/cle_slot_mem.sv
// Slot store: value and link memories, one read address, registered read data.
// Depends on cle_pkg for the data width.
`default_nettype none

module cle_slot_mem #(
   parameter int unsigned DEPTH  = cle_pkg::CAPACITY_DEF,
   parameter int unsigned ADDR_W = $clog2(cle_pkg::CAPACITY_DEF)
) (
   input  wire logic                              clock,
   input  wire logic                              val_we,
   input  wire logic [ADDR_W-1:0]                 val_waddr,
   input  wire logic signed [cle_pkg::DATA_W-1:0] val_wdata,
   input  wire logic                              lnk_we,
   input  wire logic [ADDR_W-1:0]                 lnk_waddr,
   input  wire logic [ADDR_W-1:0]                 lnk_wdata,
   input  wire logic [ADDR_W-1:0]                 rd_addr,
   output logic signed [cle_pkg::DATA_W-1:0]      rd_value,
   output logic [ADDR_W-1:0]                      rd_link
);

   logic signed [cle_pkg::DATA_W-1:0] values_mem [DEPTH];
   logic [ADDR_W-1:0]                 links_mem  [DEPTH];
   logic signed [cle_pkg::DATA_W-1:0] rd_value_ff;
   logic [ADDR_W-1:0]                 rd_link_ff;

   always_ff @(posedge clock) begin
      if (val_we) begin
         values_mem[val_waddr] <= val_wdata;
      end
      rd_value_ff <= values_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (lnk_we) begin
         links_mem[lnk_waddr] <= lnk_wdata;
      end
      rd_link_ff <= links_mem[rd_addr];
   end

   assign rd_value = rd_value_ff;
   assign rd_link  = rd_link_ff;

endmodule

`default_nettype wire

### src/cle_free_map.sv
// Slot occupancy map with a registered lowest-free-slot search.
// Depends on cle_pkg for the default capacity.
`default_nettype none

module cle_free_map #(
   parameter int unsigned DEPTH  = cle_pkg::CAPACITY_DEF,
   parameter int unsigned ADDR_W = $clog2(cle_pkg::CAPACITY_DEF)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              set_en,
   input  wire logic [ADDR_W-1:0] set_idx,
   input  wire logic              clr_en,
   input  wire logic [ADDR_W-1:0] clr_idx,
   output logic [ADDR_W-1:0]      free_idx
);

   logic [DEPTH-1:0]  in_use_ff;
   logic [DEPTH-1:0]  in_use_in;
   logic [ADDR_W-1:0] free_idx_ff;
   logic [ADDR_W-1:0] free_idx_in;

   always_comb begin
      in_use_in = in_use_ff;
      if (set_en) begin
         in_use_in[set_idx] = 1'b1;
      end
      if (clr_en) begin
         in_use_in[clr_idx] = 1'b0;
      end
   end

   // lowest clear bit; a full map gives slot zero
   always_comb begin
      free_idx_in = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_idx_in = ADDR_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else begin
         in_use_ff <= in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff <= free_idx_in;
   end

   assign free_idx = free_idx_ff;

endmodule

`default_nettype wire

### src/circular_list_engine_core.sv
// Top level of the circular list engine: command sequencer over the slot store.
// Depends on cle_pkg, cle_slot_mem and cle_free_map.
//
//   channel  | dir | handshake                 | ports
//   ---------+-----+---------------------------+---------------------------------------
//   request  | in  | start high while busy low | req_opcode, req_item_value
//   response | out | rsp_strobe, one cycle     | rsp_out_value, rsp_status,
//            |     |                           | rsp_last_of_run, rsp_entry_count
//
// Steps after acceptance of a word, state DECODE first: an insert into an empty or a
//   full list answers from DECODE, any other insert from INS_LINK; a delete or read
//   out of an empty list answers from DECODE; a delete walks in WALK to the first
//   match and answers from FIX, or from WALK when no entry matches; a read out answers
//   from WALK, one response word per cycle. The walk does one read of the slot store
//   per cycle, the next address being the link just read.
// Reset is synchronous; it empties the list at once, no clearing pass is needed.
// Response words cannot be held off; busy stays high until the last one is issued.
`default_nettype none

module circular_list_engine_core #(
   parameter int unsigned CAPACITY = cle_pkg::CAPACITY_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [cle_pkg::OP_W-1:0]          req_opcode,
   input  wire logic signed [cle_pkg::DATA_W-1:0] req_item_value,
   output logic                                   rsp_strobe,
   output logic signed [cle_pkg::DATA_W-1:0]      rsp_out_value,
   output logic [cle_pkg::ST_W-1:0]               rsp_status,
   output logic                                   rsp_last_of_run,
   output logic [cle_pkg::CNT_W-1:0]              rsp_entry_count
);

   localparam int unsigned SlotW = $clog2(CAPACITY);
   localparam int unsigned LenW  = $clog2(CAPACITY + 1);
   localparam int unsigned CntW  = cle_pkg::CNT_W;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_DECODE   = 5'b00010,
      ST_INS_LINK = 5'b00100,
      ST_WALK     = 5'b01000,
      ST_FIX      = 5'b10000
   } state_type;

   state_type                         state_ff, state_in;
   cle_pkg::opcode_type               op_ff, op_in;
   logic signed [cle_pkg::DATA_W-1:0] val_ff, val_in;
   logic [SlotW-1:0]                  head_ff, head_in;
   logic [SlotW-1:0]                  tail_ff, tail_in;
   logic [LenW-1:0]                   length_ff, length_in;
   logic [SlotW-1:0]                  cur_ff, cur_in;
   logic [SlotW-1:0]                  prev_ff, prev_in;
   logic [SlotW-1:0]                  nxt_ff, nxt_in;
   logic [SlotW-1:0]                  n_ff, n_in;

   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic signed [cle_pkg::DATA_W-1:0] rsp_value_ff, rsp_value_in;
   cle_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic [CntW-1:0]                   rsp_count_ff, rsp_count_in;

   // slot store and free map hook-up
   logic                              val_we;
   logic                              lnk_we;
   logic [SlotW-1:0]                  lnk_waddr;
   logic [SlotW-1:0]                  lnk_wdata;
   logic [SlotW-1:0]                  rd_addr;
   logic signed [cle_pkg::DATA_W-1:0] rd_value;
   logic [SlotW-1:0]                  rd_link;
   logic                              map_set;
   logic                              map_clr;
   logic [SlotW-1:0]                  free_idx;

   logic                              walk_last;
   logic                              list_empty;
   logic                              list_full;

   cle_slot_mem #(
      .DEPTH  (CAPACITY),
      .ADDR_W (SlotW)
   ) u_slot_mem (
      .clock     (clock),
      .val_we    (val_we),
      .val_waddr (free_idx),
      .val_wdata (val_ff),
      .lnk_we    (lnk_we),
      .lnk_waddr (lnk_waddr),
      .lnk_wdata (lnk_wdata),
      .rd_addr   (rd_addr),
      .rd_value  (rd_value),
      .rd_link   (rd_link)
   );

   cle_free_map #(
      .DEPTH  (CAPACITY),
      .ADDR_W (SlotW)
   ) u_free_map (
      .clock    (clock),
      .reset    (reset),
      .set_en   (map_set),
      .set_idx  (free_idx),
      .clr_en   (map_clr),
      .clr_idx  (cur_ff),
      .free_idx (free_idx)
   );

   assign walk_last  = ((LenW'(n_ff) + LenW'(1)) == length_ff);
   assign list_empty = (length_ff == '0);
   assign list_full  = (length_ff >= LenW'(CAPACITY));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      length_in     = length_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      nxt_in        = nxt_ff;
      n_in          = n_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      val_we        = 1'b0;
      lnk_we        = 1'b0;
      lnk_waddr     = free_idx;
      lnk_wdata     = head_ff;
      rd_addr       = head_ff;
      map_set       = 1'b0;
      map_clr       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // capture the request word; work starts next cycle
            if (start) begin
               op_in    = cle_pkg::opcode_type'(req_opcode);
               val_in   = req_item_value;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            unique case (op_ff)
               cle_pkg::OP_FRONT, cle_pkg::OP_BACK: begin
                  if (list_full) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = cle_pkg::STAT_FULL;
                     state_in      = ST_IDLE;
                  end else begin
                     // new slot links to the head, or to itself in an empty list
                     val_we    = 1'b1;
                     lnk_we    = 1'b1;
                     lnk_waddr = free_idx;
                     lnk_wdata = list_empty ? free_idx : head_ff;
                     if (list_empty) begin
                        head_in       = free_idx;
                        tail_in       = free_idx;
                        map_set       = 1'b1;
                        length_in     = length_ff + LenW'(1);
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = cle_pkg::STAT_OK;
                        state_in      = ST_IDLE;
                     end else begin
                        state_in = ST_INS_LINK;
                     end
                  end
               end
               cle_pkg::OP_DELETE, cle_pkg::OP_READ: begin
                  if (list_empty) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = cle_pkg::STAT_EMPTY;
                     state_in      = ST_IDLE;
                  end else begin
                     // read the head; the tail is its predecessor
                     rd_addr  = head_ff;
                     cur_in   = head_ff;
                     prev_in  = tail_ff;
                     n_in     = '0;
                     state_in = ST_WALK;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
            rsp_value_in = '0;
            rsp_last_in  = 1'b1;
         end

         ST_INS_LINK: begin
            // close the ring: old tail points at the new slot
            lnk_we    = 1'b1;
            lnk_waddr = tail_ff;
            lnk_wdata = free_idx;
            if (op_ff == cle_pkg::OP_FRONT) begin
               head_in = free_idx;
            end else begin
               tail_in = free_idx;
            end
            map_set       = 1'b1;
            length_in     = length_ff + LenW'(1);
            rsp_strobe_in = 1'b1;
            rsp_value_in  = '0;
            rsp_status_in = cle_pkg::STAT_OK;
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end

         ST_WALK: begin
            // rd_value/rd_link belong to slot cur_ff
            if (op_ff == cle_pkg::OP_READ) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = rd_value;
               rsp_status_in = cle_pkg::STAT_OK;
               rsp_last_in   = walk_last;
               if (walk_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_addr = rd_link;
                  cur_in  = rd_link;
                  n_in    = n_ff + SlotW'(1);
               end
            end else if (rd_value == val_ff) begin
               nxt_in   = rd_link;
               state_in = ST_FIX;
            end else if (walk_last) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = cle_pkg::STAT_NOT_FOUND;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               rd_addr = rd_link;
               prev_in = cur_ff;
               cur_in  = rd_link;
               n_in    = n_ff + SlotW'(1);
            end
         end

         ST_FIX: begin
            // unlink cur_ff; drop it from the free map
            if (length_ff == LenW'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else begin
               lnk_we    = 1'b1;
               lnk_waddr = prev_ff;
               lnk_wdata = nxt_ff;
               if (cur_ff == head_ff) begin
                  head_in = nxt_ff;
               end
               if (cur_ff == tail_ff) begin
                  tail_in = prev_ff;
               end
            end
            map_clr       = 1'b1;
            length_in     = length_ff - LenW'(1);
            rsp_strobe_in = 1'b1;
            rsp_value_in  = '0;
            rsp_status_in = cle_pkg::STAT_OK;
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase

      if (rsp_strobe_in) begin
         rsp_count_in = CntW'(length_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         length_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         length_ff     <= length_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      val_ff       <= val_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      nxt_ff       <= nxt_in;
      n_ff         <= n_in;
      rsp_value_ff <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

`default_nettype wire

### src/cle_checker.sv
// Port-level checker for circular_list_engine_core, bound to the top level.
// Depends on cle_pkg and circular_list_engine_core_defines.svh.
`default_nettype none
`include "circular_list_engine_core_defines.svh"

module cle_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              rsp_strobe,
   input wire logic signed [cle_pkg::DATA_W-1:0] rsp_out_value,
   input wire logic [cle_pkg::ST_W-1:0]          rsp_status,
   input wire logic                              rsp_last_of_run,
   input wire logic [cle_pkg::CNT_W-1:0]         rsp_entry_count
);

   logic accepted;
   logic rsp_fail;
   logic rsp_empty;
   logic fail_word_ok;
   logic count_zero;
   logic busy_quiet;
   logic idle_quiet;

   assign accepted     = start && !busy;
   assign rsp_fail     = rsp_strobe && (rsp_status != cle_pkg::STAT_OK);
   assign rsp_empty    = rsp_strobe && (rsp_status == cle_pkg::STAT_EMPTY);
   assign fail_word_ok = rsp_last_of_run && (rsp_out_value == '0);
   assign count_zero   = (rsp_entry_count == '0);
   assign busy_quiet   = busy && !rsp_strobe;
   assign idle_quiet   = !busy && !rsp_strobe;

   // an accepted word holds the engine busy and issues no response next cycle
   `CLE_ASSERT_NEXT(a_accept_busy, clock, reset, accepted, busy_quiet, "no busy after accept")

   // a refused or failed operation gives exactly one word, carrying value zero
   `CLE_ASSERT_NOW(a_fail_single, clock, reset, rsp_fail, fail_word_ok, "bad failed word")

   // an empty report always shows an empty list
   `CLE_ASSERT_NOW(a_empty_count, clock, reset, rsp_empty, count_zero, "entries on empty")

   // reset leaves the engine idle with no response pending
   `CLE_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, idle_quiet, "engine not idle after reset")

endmodule

bind circular_list_engine_core cle_checker u_cle_checker (.*);

`default_nettype wire

### test/cle_list_shadow.sv
// Shadow copy of the circular list and response-word checker for the list engine.
// Depends on cle_pkg; instantiated beside the block by circular_list_engine_core_test.

module cle_list_shadow #(
   parameter int unsigned CAPACITY = cle_pkg::CAPACITY_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              busy,
   input  wire logic [cle_pkg::OP_W-1:0]          req_opcode,
   input  wire logic signed [cle_pkg::DATA_W-1:0] req_item_value,
   input  wire logic                              rsp_strobe,
   input  wire logic signed [cle_pkg::DATA_W-1:0] rsp_out_value,
   input  wire logic [cle_pkg::ST_W-1:0]          rsp_status,
   input  wire logic                              rsp_last_of_run,
   input  wire logic [cle_pkg::CNT_W-1:0]         rsp_entry_count,
   output int unsigned                            fail_count,
   output int unsigned                            pending_words,
   output int unsigned                            words_checked,
   output int unsigned                            full_refusals,
   output int unsigned                            empty_hits,
   output int unsigned                            missed_deletes,
   output int unsigned                            longest_readout
);
   timeunit 1ns;
   timeprecision 1ps;

   import cle_pkg::*;

   localparam int unsigned SLOT_W = $clog2(CAPACITY);

   typedef logic [SLOT_W-1:0] slot_t;
   typedef logic [CNT_W-1:0]  count_t;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      status_type               status;
      logic                     last;
      count_t                   count;
   } rsp_word_t;

   logic signed [DATA_W-1:0] slot_value [CAPACITY];
   slot_t                    slot_link  [CAPACITY];
   logic [CAPACITY-1:0]      slot_taken;
   slot_t                    head;
   slot_t                    tail;
   count_t                   length;
   rsp_word_t                expected_words [$];

   task automatic record_fault(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("[%0t] MISMATCH %s", $time, msg);
      end
   endtask

   task automatic push_word(input logic signed [DATA_W-1:0] value, input status_type status,
                            input logic last);
      rsp_word_t w;
      w.value  = value;
      w.status = status;
      w.last   = last;
      w.count  = length;
      expected_words.push_back(w);
   endtask

   // New entries take the lowest free slot; the tail always links back to the head.
   task automatic insert_entry(input logic signed [DATA_W-1:0] v, input logic at_front);
      slot_t       s;
      logic        found;
      int unsigned i;
      if (length >= CAPACITY) begin
         full_refusals++;
         push_word('0, STAT_FULL, 1'b1);
      end else begin
         s     = '0;
         found = 1'b0;
         for (i = 0; i < CAPACITY; i++) begin
            if (!found && !slot_taken[i]) begin
               s     = slot_t'(i);
               found = 1'b1;
            end
         end
         slot_taken[s] = 1'b1;
         slot_value[s] = v;
         if (length == 0) begin
            slot_link[s] = s;
            head         = s;
            tail         = s;
         end else begin
            slot_link[s]    = head;
            slot_link[tail] = s;
            if (at_front) begin
               head = s;
            end else begin
               tail = s;
            end
         end
         length = length + 1'b1;
         push_word('0, STAT_OK, 1'b1);
      end
   endtask

   // Walk from the head, dragging the predecessor along, and unlink the first match.
   task automatic delete_entry(input logic signed [DATA_W-1:0] v);
      slot_t       cur;
      slot_t       prev;
      logic        hit;
      int unsigned n;
      if (length == 0) begin
         empty_hits++;
         push_word('0, STAT_EMPTY, 1'b1);
      end else begin
         cur  = head;
         prev = tail;
         hit  = 1'b0;
         n    = 0;
         while (!hit && n < length) begin
            if (slot_value[cur] == v) begin
               hit = 1'b1;
            end else begin
               prev = cur;
               cur  = slot_link[cur];
               n++;
            end
         end
         if (!hit) begin
            missed_deletes++;
            push_word('0, STAT_NOT_FOUND, 1'b1);
         end else begin
            if (length == 1) begin
               head = '0;
               tail = '0;
            end else begin
               slot_link[prev] = slot_link[cur];
               if (cur == head) begin
                  head = slot_link[cur];
               end
               if (cur == tail) begin
                  tail = prev;
               end
            end
            slot_taken[cur] = 1'b0;
            length = length - 1'b1;
            push_word('0, STAT_OK, 1'b1);
         end
      end
   endtask

   task automatic read_out_list();
      slot_t       cur;
      int unsigned n;
      if (length == 0) begin
         empty_hits++;
         push_word('0, STAT_EMPTY, 1'b1);
      end else begin
         cur = head;
         for (n = 0; n < length; n++) begin
            push_word(slot_value[cur], STAT_OK, (n + 1 == length));
            cur = slot_link[cur];
         end
         if (length > longest_readout) begin
            longest_readout = length;
         end
      end
   endtask

   task automatic check_word();
      rsp_word_t want;
      if (expected_words.size() == 0) begin
         record_fault($sformatf("unexpected word: value %0d status %0d last %0b count %0d",
                                rsp_out_value, rsp_status, rsp_last_of_run, rsp_entry_count));
      end else begin
         want = expected_words.pop_front();
         words_checked++;
         if (rsp_out_value !== want.value || rsp_status !== want.status ||
             rsp_last_of_run !== want.last || rsp_entry_count !== want.count) begin
            record_fault($sformatf({"word %0d: expected value %0d status %s last %0b count %0d,",
                                    " got value %0d status %0d last %0b count %0d"},
                                   words_checked, want.value, want.status.name(), want.last,
                                   want.count, rsp_out_value, rsp_status, rsp_last_of_run,
                                   rsp_entry_count));
         end
      end
   endtask

   // Compare before predicting: the last word of one command may leave on the same
   // edge that accepts the next command.
   always @(posedge clock) begin
      if (reset) begin
         slot_taken      = '0;
         head            = '0;
         tail            = '0;
         length          = '0;
         expected_words.delete();
         fail_count      = 0;
         words_checked   = 0;
         full_refusals   = 0;
         empty_hits      = 0;
         missed_deletes  = 0;
         longest_readout = 0;
      end else begin
         if (rsp_strobe) begin
            check_word();
         end
         if (start && !busy) begin
            case (opcode_type'(req_opcode))
               OP_FRONT:  insert_entry(req_item_value, 1'b1);
               OP_BACK:   insert_entry(req_item_value, 1'b0);
               OP_DELETE: delete_entry(req_item_value);
               default:   read_out_list();
            endcase
         end
      end
      pending_words = expected_words.size();
   end

endmodule

### test/circular_list_engine_core_test.sv
// Top of the circular list engine testbench: clock, reset, command stimulus and verdict.
// Depends on cle_pkg, circular_list_engine_core and cle_list_shadow.

module circular_list_engine_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cle_pkg::*;

   localparam int unsigned CAPACITY       = CAPACITY_DEF;
   // Longest command is a delete that matches the last entry; allow a little slack past it.
   localparam int unsigned DRAIN_CYCLES   = CAPACITY + 4;
   // Quiet cycles tolerated before the run is declared hung.
   localparam int unsigned WATCHDOG_LIMIT = 3000;

   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [OP_W-1:0]          req_opcode;
   logic signed [DATA_W-1:0] req_item_value;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_out_value;
   logic [ST_W-1:0]          rsp_status;
   logic                     rsp_last_of_run;
   logic [CNT_W-1:0]         rsp_entry_count;

   int unsigned fail_count;
   int unsigned pending_words;
   int unsigned words_checked;
   int unsigned full_refusals;
   int unsigned empty_hits;
   int unsigned missed_deletes;
   int unsigned longest_readout;

   int unsigned gap_pct;       // chance in a hundred of idling before each command word
   int unsigned commands_sent;
   int unsigned quiet_cycles;

   circular_list_engine_core #(
      .CAPACITY (CAPACITY)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_item_value  (req_item_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_value   (rsp_out_value),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_entry_count (rsp_entry_count)
   );

   // The shadow list watches both channels, predicts every response word and compares.
   cle_list_shadow #(
      .CAPACITY (CAPACITY)
   ) u_shadow (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_item_value  (req_item_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_value   (rsp_out_value),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_entry_count (rsp_entry_count),
      .fail_count      (fail_count),
      .pending_words   (pending_words),
      .words_checked   (words_checked),
      .full_refusals   (full_refusals),
      .empty_hits      (empty_hits),
      .missed_deletes  (missed_deletes),
      .longest_readout (longest_readout)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hand one command word to the block. Idle first at the current gap rate, putting
   // junk on the request ports while start is low, then hold start until busy is low
   // at an edge. Only one assignment to start falls in any one time step.
   task automatic send_word(input opcode_type op, input logic signed [DATA_W-1:0] v);
      while ($urandom_range(99) < gap_pct) begin
         start          <= 1'b0;
         req_opcode     <= OP_W'($urandom_range(3));
         req_item_value <= $urandom;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_item_value <= v;
      do @(posedge clock); while (busy);
      commands_sent++;
   endtask

   // Random commands in bursts. Each burst draws its own mood (drain, churn or fill)
   // so the list swings between empty and full, and its own small value pool so that
   // most deletes hit, duplicates appear and first-match order gets exercised.
   task automatic run_random(input int unsigned count);
      logic signed [DATA_W-1:0] pool [8];
      logic signed [DATA_W-1:0] v;
      opcode_type               op;
      int unsigned              k;
      int unsigned              j;
      int unsigned              sel;
      int unsigned              insert_pct;
      for (k = 0; k < count; k++) begin
         if (k % 24 == 0) begin
            case ($urandom_range(2))
               0:       insert_pct = 15;
               1:       insert_pct = 50;
               default: insert_pct = 92;
            endcase
            for (j = 0; j < 8; j++) begin
               if ($urandom_range(7) == 0) begin
                  case ($urandom_range(3))
                     0:       pool[j] = VALUE_MIN;
                     1:       pool[j] = VALUE_MAX;
                     2:       pool[j] = '0;
                     default: pool[j] = -32'sd1;
                  endcase
               end else begin
                  pool[j] = $urandom;
               end
            end
         end
         sel = $urandom_range(99);
         if (sel < 10) begin
            op = OP_READ;
         end else if (sel < 10 + insert_pct * 90 / 100) begin
            op = ($urandom_range(1) == 0) ? OP_FRONT : OP_BACK;
         end else begin
            op = OP_DELETE;
         end
         if ($urandom_range(99) < 70) begin
            v = pool[$urandom_range(7)];
         end else begin
            v = $urandom;
         end
         send_word(op, v);
      end
   endtask

   // Hang guard: count edges at which neither a command nor a response word moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
         $display("circular_list_engine_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic signed [DATA_W-1:0] tail_value;
      int unsigned              i;

      // Initialise every input before the first edge, with reset held high, then release reset.
      reset          <= 1'b1;
      start          <= 1'b0;
      req_opcode     <= OP_FRONT;
      req_item_value <= '0;
      commands_sent   = 0;
      gap_pct         = 30;
      tail_value      = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty list: read-out and delete both report empty; then a lone entry that is
      // deleted again, leaving the list empty.
      send_word(OP_READ, 32'sd0);
      send_word(OP_DELETE, 32'sd7);
      send_word(OP_FRONT, 32'sd7);
      send_word(OP_DELETE, 32'sd7);

      // Extremes of the value field, at both ends: list becomes 0, MIN, MAX, -1.
      send_word(OP_FRONT, VALUE_MIN);
      send_word(OP_BACK, VALUE_MAX);
      send_word(OP_FRONT, '0);
      send_word(OP_BACK, -32'sd1);

      // Fill to capacity, then try one more insert and read out the full list.
      for (i = 0; i < CAPACITY - 4; i++) begin
         tail_value = $urandom;
         send_word(OP_BACK, tail_value);
      end
      send_word(OP_FRONT, 32'sd1);
      send_word(OP_READ, 32'sd0);

      // Unmatched delete, then delete from the middle, the head and the tail.
      send_word(OP_DELETE, 32'sh5a5a_5a5a);
      send_word(OP_DELETE, VALUE_MIN);
      send_word(OP_DELETE, '0);
      send_word(OP_DELETE, tail_value);

      // Random traffic: moderate sender gaps, then heavy gaps, then back to back.
      run_random(145);
      gap_pct = 83;
      run_random(145);
      gap_pct = 0;
      run_random(145);

      // Drop start, wait for every predicted word, then give the block time to show
      // any stray extra words.
      start <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d commands, checked %0d response words, longest read-out %0d",
               commands_sent, words_checked, longest_readout);
      $display("full refusals %0d, empty-list reports %0d, unmatched deletes %0d",
               full_refusals, empty_hits, missed_deletes);
      if (pending_words != 0) begin
         $display("%0d predicted response words never arrived", pending_words);
      end
      if (fail_count == 0 && pending_words == 0) begin
         $display("circular_list_engine_core test passed");
      end else begin
         $display("circular_list_engine_core test failed");
      end
      $finish;
   end

endmodule

### circular_list_engine_core.f
+incdir+src
src/cle_pkg.sv
src/cle_slot_mem.sv
src/cle_free_map.sv
src/circular_list_engine_core.sv
src/cle_checker.sv
test/cle_list_shadow.sv
test/circular_list_engine_core_test.sv
